>>> rtl/core/kernel_select_conv2d_unit_macros.svh
// Assertion macros for the convolution block.
`ifndef KERNEL_SELECT_CONV2D_UNIT_MACROS_SVH
`define KERNEL_SELECT_CONV2D_UNIT_MACROS_SVH
// Implication checked on every clock edge, disabled in reset.
`define KSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge, disabled in reset.
`define KSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/core/ksc_pkg.sv
// Shared constants, types and kernel tables for the convolution block.
package ksc_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxKernel = 6;
  localparam int PixBits   = 8;
  localparam int Lines     = MaxKernel - 1;
  localparam int ColBits   = $clog2(MaxWidth);
  localparam int AccBits   = 32;
  localparam int OutBits   = 21;

  typedef logic [PixBits-1:0] pix_t;
  typedef logic [3:0]         kind_t;
  typedef logic signed [7:0]  coef_t;

  localparam logic [1:0] CFG_KIND   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam kind_t K_DX = 4'd0, K_DY = 4'd1, K_DXX = 4'd2, K_DYY = 4'd3,
    K_DXY = 4'd4, K_LAP = 4'd5, K_SM2 = 4'd6, K_SM3 = 4'd7, K_SM4 = 4'd8,
    K_SM5 = 4'd9, K_SM6 = 4'd10, K_DOG = 4'd11;

  // control word carried beside a row of window products
  typedef struct packed {
    logic       vld;
    logic       last;
    logic [3:0] shift;
    kind_t      kind;
  } ctl_t;

  function automatic logic signed [8:0] bino(input int n, input int i);
    int v;
    begin
      v = 0;
      unique case (n)
        2: v = 1;
        3: v = (i == 1) ? 2 : 1;
        4: v = (i == 0 || i == 3) ? 1 : 3;
        5: v = (i == 0 || i == 4) ? 1 : ((i == 2) ? 6 : 4);
        6: v = (i == 0 || i == 5) ? 1 : ((i == 1 || i == 4) ? 5 : 10);
        default: v = 0;
      endcase
      return 9'(v);
    end
  endfunction

  // weight of window tap (a rows up, b columns left)
  function automatic logic signed [8:0] coef(input kind_t k, input int a, input int b);
    int v;
    int d [0:4][0:4];
    begin
      d = '{'{1,-12,-26,-12,1}, '{-12,-16,-40,-16,-12}, '{-26,-40,-92,-40,-26},
            '{-12,-16,-40,-16,-12}, '{1,-12,-26,-12,1}};
      v = 0;
      unique case (k)
        K_DX:  v = (a < 2 && b < 2) ? ((b == 0) ? 1 : -1) : 0;
        K_DY:  v = (a < 2 && b < 2) ? ((a == 0) ? 1 : -1) : 0;
        K_DXX: v = (a < 3 && b < 3) ? int'(bino(3, a)) * ((b == 1) ? -2 : 1) : 0;
        K_DYY: v = (a < 3 && b < 3) ? int'(bino(3, b)) * ((a == 1) ? -2 : 1) : 0;
        K_DXY: v = (a < 3 && b < 3) ? (a - 1) * (b - 1) : 0;
        K_LAP: v = (a < 3 && b < 3) ? ((a == 1 && b == 1) ? -8 :
                   ((a != 1 && b != 1) ? 2 : 0)) : 0;
        K_SM2: v = (a < 2 && b < 2) ? 1 : 0;
        K_SM3: v = (a < 3 && b < 3) ? int'(bino(3, a)) * int'(bino(3, b)) : 0;
        K_SM4: v = (a < 4 && b < 4) ? int'(bino(4, a)) * int'(bino(4, b)) : 0;
        K_SM5: v = (a < 5 && b < 5) ? int'(bino(5, a)) * int'(bino(5, b)) : 0;
        K_SM6: v = int'(bino(6, a)) * int'(bino(6, b));
        default: v = (a < 5 && b < 5) ? d[a][b] : 0;
      endcase
      return 9'(v);
    end
  endfunction

  function automatic logic [2:0] ksize(input kind_t k);
    unique case (k)
      K_DX, K_DY, K_SM2: return 3'd2;
      K_DXX, K_DYY, K_DXY, K_LAP, K_SM3: return 3'd3;
      K_SM4: return 3'd4;
      K_SM6: return 3'd6;
      default: return 3'd5;
    endcase
  endfunction

  // log2 of 1024 / divisor
  function automatic logic [3:0] kshift(input kind_t k);
    unique case (k)
      K_DX, K_DY: return 4'd9;
      K_DXX, K_DYY, K_DXY, K_LAP, K_SM2: return 4'd8;
      K_SM3: return 4'd6;
      K_SM4: return 4'd4;
      K_SM6: return 4'd0;
      default: return 4'd2;
    endcase
  endfunction
endpackage

>>> rtl/core/ksc_line_cell.sv
// One line-buffer cell: one stored row, read on accept, written back in the following cycle.
module ksc_line_cell (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ksc_pkg::ColBits-1:0] wr_col,
  input  ksc_pkg::pix_t               din,
  input  logic                        rd_en,
  input  logic [ksc_pkg::ColBits-1:0] rd_col,
  output ksc_pkg::pix_t               dout
);
  import ksc_pkg::*;
  pix_t mem [0:MaxWidth-1];
  pix_t rd_r;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_col] <= din;
    if (rd_en) rd_r <= mem[rd_col];
  end
  assign dout = rd_r;
endmodule

>>> rtl/core/ksc_row_cell.sv
// One window row: six pixel taps, row partial sum, passes sum down the chain.
module ksc_row_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            tap_en,
  input  logic [2:0]                      row,
  input  ksc_pkg::pix_t                   pix_in,
  input  logic signed [ksc_pkg::AccBits-1:0] sum_in,
  input  ksc_pkg::ctl_t                   ctl_in,
  output logic signed [ksc_pkg::AccBits-1:0] sum_out,
  output ksc_pkg::ctl_t                   ctl_out
);
  import ksc_pkg::*;
  pix_t tap_r [0:MaxKernel-2];
  logic signed [AccBits-1:0] sum_r;
  ctl_t ctl_r;
  pix_t win [0:MaxKernel-1];
  logic signed [8:0] wt [0:MaxKernel-1];
  logic signed [AccBits-1:0] part;

  // window row as it stands once this word is shifted in
  always_comb begin
    win[0] = pix_in;
    for (int b = 1; b < MaxKernel; b++) win[b] = tap_r[b-1];
  end

  always_comb begin
    part = sum_in;
    for (int b = 0; b < MaxKernel; b++) begin
      wt[b] = coef(ctl_in.kind, int'(row), b);
      // zero-weight taps may hold line entries not yet written
      if (wt[b] != 9'sd0)
        part = part + AccBits'(wt[b]) * AccBits'($signed({1'b0, win[b]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < MaxKernel - 1; b++) tap_r[b] <= '0;
      ctl_r <= '0;
    end else begin
      if (tap_en) begin
        tap_r[0] <= pix_in;
        for (int b = 1; b < MaxKernel - 1; b++) tap_r[b] <= tap_r[b-1];
      end
      if (en) ctl_r <= ctl_in;
    end
  end
  always_ff @(posedge clk) if (en) sum_r <= part;

  assign sum_out = sum_r;
  assign ctl_out = ctl_r;
endmodule

>>> rtl/core/kernel_select_conv2d_unit.sv
// Top level: line-buffer and window-row cell chains with stream ports.
// Streaming 2-D convolution of an 8-bit grey raster with one of twelve
// built-in kernels (dx, dy, dxx, dyy, dxy, Laplace, binomial 2..6, DoG).
// One pixel word is taken every clock while the output is not stalled; the
// pipeline (line-buffer read, then six row cells that each add one window
// row's weighted taps and pass the partial sum to the next, then the output
// register) moves only when the output register is free or being taken, so
// the rate is one word per cycle unless stalled. Result words are signed
// 21-bit in units of 1/1024; tuser carries frame_end on the last result of
// the frame. The kernel choice travels with each word, so a kind change
// applies from the next pixel on. Configuration is to be written between
// frames; the block itself does not enforce it. Kind 12..15 acts as DoG and
// dimensions are clamped to 2..1024 wide and 2..4096 high.
module kernel_select_conv2d_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] filtered, zero fill above
  output logic        out_tuser,  // [0] frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import ksc_pkg::*;
  `include "kernel_select_conv2d_unit_macros.svh"

  kind_t       kind_r;
  logic [10:0] fw_r;
  logic [12:0] fh_r;
  logic [10:0] col_r;
  logic [12:0] row_r;
  // front stage: pixel plus position, registered alongside the line reads
  logic        s0_vld_r;
  pix_t        s0_pix_r;
  logic [ColBits-1:0] s0_col_r;
  ctl_t        s0_ctl_r;
  logic        en;
  logic        o_vld_r;
  logic [OutBits-1:0] o_dat_r;
  logic        o_last_r;
  logic [ColBits-1:0] cidx;

  assign en        = !o_vld_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign cidx      = col_r[ColBits-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= K_SM3; fw_r <= 11'd640; fh_r <= 13'd480;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_KIND)   kind_r <= cfg_data[3:0];
      if (cfg_index == CFG_WIDTH)  fw_r   <= cfg_data[10:0];
      if (cfg_index == CFG_HEIGHT) fh_r   <= cfg_data;
    end
  end

  kind_t       kind;
  logic [10:0] w;
  logic [12:0] h;
  logic [2:0]  sz;
  logic        fire;
  assign kind = (kind_r > K_DOG) ? K_DOG : kind_r;
  assign w = (fw_r < 11'd2) ? 11'd2 : ((fw_r > 11'(MaxWidth)) ? 11'(MaxWidth) : fw_r);
  assign h = (fh_r < 13'd2) ? 13'd2 : ((fh_r > 13'd4096) ? 13'd4096 : fh_r);
  assign sz = ksize(kind);
  assign fire = in_tvalid && en;

  ctl_t ctl_new;
  always_comb begin
    ctl_new.vld = fire && (col_r < w) && ({1'b0, row_r} < {1'b0, h}) &&
                  (col_r + 11'd1 >= 11'(sz)) && (row_r + 13'd1 >= 13'(sz));
    ctl_new.last = (col_r == w - 11'd1) && (row_r == h - 13'd1);
    ctl_new.shift = kshift(kind);
    ctl_new.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= fire;
      if (fire) begin
        if (col_r + 11'd1 >= w) begin
          col_r <= '0;
          row_r <= (row_r + 13'd1 >= h) ? '0 : row_r + 13'd1;
        end else col_r <= col_r + 11'd1;
      end
    end
  end
  always_ff @(posedge clk) if (en) begin
    s0_pix_r <= in_tdata;
    s0_col_r <= cidx;
    s0_ctl_r <= ctl_new;
  end

  // line-buffer chain: line_out[i] is the pixel i+1 rows up; each cell is
  // read at the accepted column and, in the following cycle, takes the word
  // read from the cell above it (the first cell: the pixel) at that column
  pix_t line_in  [0:Lines-1];
  pix_t line_out [0:Lines-1];
  genvar gi;
  generate
    for (gi = 0; gi < Lines; gi++) begin : g_line
      assign line_in[gi] = (gi == 0) ? s0_pix_r : line_out[(gi == 0) ? 0 : gi-1];
      ksc_line_cell u_line (
        .clk(clk), .wr_en(s0_vld_r), .wr_col(s0_col_r), .din(line_in[gi]),
        .rd_en(fire), .rd_col(cidx), .dout(line_out[gi]));
    end
  endgenerate

  // window column: pixel for row a, delayed through dly_r[a] to meet row a's cell
  pix_t col_pix [0:MaxKernel-1];
  pix_t dly_r [0:MaxKernel-1][0:MaxKernel-1];
  assign col_pix[0] = s0_pix_r;
  generate
    for (gi = 1; gi < MaxKernel; gi++) begin : g_cp
      assign col_pix[gi] = line_out[gi-1];
    end
  endgenerate

  always_ff @(posedge clk) if (en && s0_vld_r) begin
    for (int a = 0; a < MaxKernel; a++) dly_r[a][0] <= col_pix[a];
  end
  always_ff @(posedge clk) if (en) begin
    for (int a = 0; a < MaxKernel; a++)
      for (int d = 1; d < MaxKernel; d++) dly_r[a][d] <= dly_r[a][d-1];
  end

  // window taps only shift on accepted words; gate per row by stage valid
  logic signed [AccBits-1:0] sums [0:MaxKernel];
  ctl_t ctls [0:MaxKernel];
  logic [MaxKernel-1:0] vpipe_r;
  assign sums[0] = '0;
  assign ctls[0] = s0_ctl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vpipe_r <= '0;
    else if (en) vpipe_r <= {vpipe_r[MaxKernel-2:0], s0_vld_r};
  end
  generate
    for (gi = 0; gi < MaxKernel; gi++) begin : g_row
      pix_t pin;
      logic ren;
      assign pin = (gi == 0) ? col_pix[0] : dly_r[gi][(gi == 0) ? 0 : gi-1];
      assign ren = en && ((gi == 0) ? s0_vld_r : vpipe_r[(gi == 0) ? 0 : gi-1]);
      ksc_row_cell u_row (
        .clk(clk), .rst_n(rst_n), .en(en), .tap_en(ren), .row(3'(gi)),
        .pix_in(pin), .sum_in(sums[gi]), .ctl_in(ctls[gi]),
        .sum_out(sums[gi+1]), .ctl_out(ctls[gi+1]));
    end
  endgenerate

  logic signed [AccBits-1:0] scaled;
  assign scaled = sums[MaxKernel] <<< ctls[MaxKernel].shift;

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (en) o_vld_r <= ctls[MaxKernel].vld;
  end
  always_ff @(posedge clk) if (en) begin
    o_dat_r  <= scaled[OutBits-1:0];
    o_last_r <= ctls[MaxKernel].last;
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {3'b0, o_dat_r};
  assign out_tuser  = o_last_r;

  `KSC_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `KSC_ASSERT_IMP(a_rdy, out_tvalid && !out_tready, !in_tready)
  `KSC_ASSERT_IMP(a_col, 1'b1, col_r < 11'(MaxWidth))
endmodule
